// ===== hw/rtl/bclv_pkg.sv =====
// bclv_pkg: shared types, constants and opcode length table for the bytecode length validator
`default_nettype none

package bclv_pkg;

  localparam int unsigned AddrBits     = 24;
  localparam int unsigned OutAddrBits  = 24;
  localparam int unsigned LeftBits     = 11;
  localparam int unsigned OffsetBits   = 3;

  localparam logic [7:0] OpEnter  = 8'd45;
  localparam logic [7:0] OpSwitch = 8'd98;

  localparam logic [LeftBits-1:0]   EnterTail  = LeftBits'(4);
  localparam logic [LeftBits-1:0]   SwitchTail = LeftBits'(1);
  localparam logic [OffsetBits-1:0] EnterLenOffset  = OffsetBits'(4);
  localparam logic [OffsetBits-1:0] SwitchLenOffset = OffsetBits'(1);
  localparam logic [OffsetBits-1:0] OffsetMax = '1;

  typedef enum logic [2:0] {
    VerdictPending       = 3'd0,
    VerdictValid         = 3'd1,
    VerdictFirstNotEnter = 3'd2,
    VerdictBadOpcode     = 3'd3,
    VerdictTruncated     = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [OutAddrBits-1:0] byte_address;
    logic                   is_start;
    logic                   is_final;
    verdict_e               verdict;
  } out_item_t;

  // fixed opcode length, zero for invalid or variable-length opcodes
  function automatic logic [2:0] fixed_len(input logic [7:0] op);
    logic [2:0] len;
    case (op) inside
      [8'd0:8'd36], 8'd42, 8'd43, [8'd47:8'd51], 8'd63,
      [8'd99:8'd100], [8'd105:8'd126]:               len = 3'd1;
      8'd37, [8'd52:8'd62], [8'd64:8'd66],
      [8'd101:8'd104]:                               len = 3'd2;
      8'd38, 8'd46, [8'd67:8'd92]:                   len = 3'd3;
      8'd39, 8'd44, [8'd93:8'd97]:                   len = 3'd4;
      8'd40, 8'd41:                                  len = 3'd5;
      default:                                       len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bclv_in_if.sv =====
// bclv_in_if: input byte channel
`default_nettype none

interface bclv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last;

  modport source (output valid, output code_byte, output last, input ready);
  modport sink   (input valid, input code_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bclv_out_if.sv =====
// bclv_out_if: per-byte result channel
`default_nettype none

interface bclv_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] byte_address;
  logic        is_start;
  logic        is_final;
  logic [2:0]  verdict;

  modport source (output valid, output byte_address, output is_start, output is_final,
                  output verdict, input ready);
  modport sink   (input valid, input byte_address, input is_start, input is_final,
                  input verdict, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bclv_in_reg.sv =====
// bclv_in_reg: input register stage for incoming bytes
`default_nettype none

module bclv_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire bclv_pkg::in_item_t item_i,
  output logic                   ready_o,
  input  wire logic              adv_i,
  output logic                   valid_o,
  output bclv_pkg::in_item_t     item_o
);

  logic               valid_q, valid_d;
  bclv_pkg::in_item_t item_q;
  logic               load;

  assign ready_o = !valid_q || adv_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (adv_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bclv_scan.sv =====
// bclv_scan: instruction boundary tracking state and per-byte verdict logic
`default_nettype none

module bclv_scan (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire bclv_pkg::in_item_t  item_i,
  output bclv_pkg::out_item_t      res_o
);

  localparam int unsigned LB = bclv_pkg::LeftBits;
  localparam int unsigned OB = bclv_pkg::OffsetBits;
  localparam int unsigned AB = bclv_pkg::AddrBits;

  logic [AB-1:0]      addr_q, addr_d;
  logic [LB-1:0]      left_q, left_d;
  logic [OB-1:0]      offset_q, offset_d;
  logic [7:0]         opcode_q, opcode_d;
  bclv_pkg::verdict_e err_q, err_d;

  logic [2:0]         len;
  logic [OB-1:0]      offset_inc;
  logic [LB-1:0]      byte_ext;
  logic [LB-1:0]      switch_len;
  logic               start;
  bclv_pkg::verdict_e verdict;
  logic [AB+bclv_pkg::OutAddrBits-1:0] addr_ext;

  assign len        = bclv_pkg::fixed_len(item_i.code_byte);
  assign offset_inc = (offset_q != bclv_pkg::OffsetMax) ? offset_q + OB'(1) : offset_q;
  assign byte_ext   = LB'(item_i.code_byte);
  assign switch_len = (byte_ext << 2) + (byte_ext << 1);

  always_comb begin
    left_d   = left_q;
    offset_d = offset_q;
    opcode_d = opcode_q;
    err_d    = err_q;
    start    = 1'b0;
    if (err_q == bclv_pkg::VerdictPending) begin
      if (left_q == '0) begin
        start    = 1'b1;
        opcode_d = item_i.code_byte;
        offset_d = '0;
        if (addr_q == '0 && item_i.code_byte != bclv_pkg::OpEnter) begin
          err_d = bclv_pkg::VerdictFirstNotEnter;
        end else if (item_i.code_byte == bclv_pkg::OpEnter) begin
          left_d = bclv_pkg::EnterTail;
        end else if (item_i.code_byte == bclv_pkg::OpSwitch) begin
          left_d = bclv_pkg::SwitchTail;
        end else if (len == 3'd0) begin
          err_d = bclv_pkg::VerdictBadOpcode;
        end else begin
          left_d = LB'(len - 3'd1);
        end
      end else begin
        offset_d = offset_inc;
        left_d   = left_q - LB'(1);
        if (opcode_q == bclv_pkg::OpEnter && offset_inc == bclv_pkg::EnterLenOffset) begin
          left_d = byte_ext;
        end else if (opcode_q == bclv_pkg::OpSwitch &&
                     offset_inc == bclv_pkg::SwitchLenOffset) begin
          left_d = switch_len;
        end
      end
    end
  end

  always_comb begin
    if (err_d != bclv_pkg::VerdictPending) begin
      verdict = err_d;
    end else if (item_i.last) begin
      verdict = (left_d != '0) ? bclv_pkg::VerdictTruncated : bclv_pkg::VerdictValid;
    end else begin
      verdict = bclv_pkg::VerdictPending;
    end
  end

  // stream state clears after the final byte
  assign addr_d = item_i.last ? '0 : addr_q + AB'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      left_q   <= '0;
      offset_q <= '0;
      opcode_q <= '0;
      err_q    <= bclv_pkg::VerdictPending;
    end else if (adv_i) begin
      addr_q <= addr_d;
      if (item_i.last) begin
        left_q   <= '0;
        offset_q <= '0;
        opcode_q <= '0;
        err_q    <= bclv_pkg::VerdictPending;
      end else begin
        left_q   <= left_d;
        offset_q <= offset_d;
        opcode_q <= opcode_d;
        err_q    <= err_d;
      end
    end
  end

  assign addr_ext           = {{bclv_pkg::OutAddrBits{1'b0}}, addr_q};
  assign res_o.byte_address = addr_ext[bclv_pkg::OutAddrBits-1:0];
  assign res_o.is_start     = start;
  assign res_o.is_final     = item_i.last;
  assign res_o.verdict      = verdict;

endmodule

`default_nettype wire

// ===== hw/rtl/bclv_out_reg.sv =====
// bclv_out_reg: result register toward the output channel
`default_nettype none

module bclv_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire bclv_pkg::out_item_t item_i,
  output logic                     ready_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output bclv_pkg::out_item_t      item_o
);

  logic                valid_q, valid_d;
  bclv_pkg::out_item_t item_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bytecode_length_validator.sv =====
// bytecode_length_validator: top level of the streaming bytecode length checker
//
// in_i carries one bytecode byte per transfer, with last set on the final byte of
// the code section. out_o returns exactly one result per input byte, in order:
// the byte's offset in the stream, whether it starts an instruction, a copy of
// last, and a verdict (pending, valid, first opcode not enter, invalid opcode,
// truncated instruction). Errors stick until the final byte of the stream.
// After a final byte all scan state clears and the next byte starts a new
// stream at offset 0.
// A byte taken by the input register is scanned on its way to the result
// register, from which the receiver can take it.
// Throughput: one byte per cycle while the receiver keeps ready high; the scan
// state updates as a byte moves from the input register to the result register.
// Stalls: while the receiver holds ready low, the result register holds and the
// input register still takes one more byte; in_i.ready falls only when both
// are full. Reset (rst_ni low, asynchronous) empties both registers and
// returns the scan state to the start of a stream.
`default_nettype none

module bytecode_length_validator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bclv_in_if.sink    in_i,
  bclv_out_if.source out_o
);

  bclv_pkg::in_item_t  in_item;
  bclv_pkg::in_item_t  s1_item;
  bclv_pkg::out_item_t scan_res;
  bclv_pkg::out_item_t out_item;
  logic                s1_valid;
  logic                out_room;
  logic                adv;
  logic                in_ready;

  assign in_item.code_byte = in_i.code_byte;
  assign in_item.last      = in_i.last;
  assign adv               = s1_valid && out_room;

  bclv_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .item_i  (in_item),
    .ready_o (in_ready),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  bclv_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (s1_item),
    .res_o  (scan_res)
  );

  bclv_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .item_i  (scan_res),
    .ready_o (out_room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .item_o  (out_item)
  );

  assign in_i.ready         = in_ready;
  assign out_o.byte_address = out_item.byte_address;
  assign out_o.is_start     = out_item.is_start;
  assign out_o.is_final     = out_item.is_final;
  assign out_o.verdict      = out_item.verdict;

  // a missing enter can only be flagged on the opening opcode
  a_first_not_enter_at_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.is_start && out_item.verdict == bclv_pkg::VerdictFirstNotEnter)
      |-> (out_o.byte_address == '0))
    else $error("first-opcode error away from offset zero");

  // success and truncation are only reported on the final byte
  a_end_verdict_on_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_item.verdict == bclv_pkg::VerdictValid ||
                     out_item.verdict == bclv_pkg::VerdictTruncated))
      |-> out_o.is_final)
    else $error("end-of-stream verdict on a non-final byte");

  // a byte that leaves the input register lands in the result register
  a_adv_loads_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_o.valid)
    else $error("advanced byte missing from result register");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for bytecode_length_validator: directed and random bytecode streams checked per byte
`timescale 1ns / 1ps

module testbench;
  import bclv_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  localparam logic [7:0] OpTwoByte   = 8'd37;
  localparam logic [7:0] OpLastValid = 8'd126;
  localparam logic [7:0] OpAllOnes   = 8'hFF;
  localparam int unsigned SwitchCaseBytes = 6;
  localparam int unsigned MaxIdle = 12;
  localparam int unsigned SettleCycles = 4;

  logic clk;
  logic rst_n;
  bit   send_idle_on;
  bit   recv_idle_on;
  int unsigned mismatches;

  // scan state of the prediction
  logic [AddrBits-1:0]   scan_addr;
  logic [LeftBits-1:0]   bytes_owed;
  logic [OffsetBits-1:0] instr_off;
  logic [7:0]            cur_op;
  verdict_e              sticky_err;

  out_item_t scan_results_due [$];

  bclv_in_if  byte_ch ();
  bclv_out_if result_ch ();

  bytecode_length_validator DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (result_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned op_length(input logic [7:0] op);
    if (op == OpEnter || op == OpSwitch || op > OpLastValid) return 0;
    if (op == 8'd40 || op == 8'd41) return 5;
    if (op == 8'd39 || op == 8'd44 || (op >= 8'd93 && op <= 8'd97)) return 4;
    if (op == 8'd38 || op == 8'd46 || (op >= 8'd67 && op <= 8'd92)) return 3;
    if (op == 8'd37 || (op >= 8'd52 && op <= 8'd62) || (op >= 8'd64 && op <= 8'd66) ||
        (op >= 8'd101 && op <= 8'd104)) return 2;
    return 1;
  endfunction

  function automatic void clear_scan();
    scan_addr  = '0;
    bytes_owed = '0;
    instr_off  = '0;
    cur_op     = '0;
    sticky_err = VerdictPending;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic fin);
    out_item_t res;
    res.byte_address = OutAddrBits'(scan_addr);
    res.is_start     = 1'b0;
    res.is_final     = fin;
    if (sticky_err == VerdictPending) begin
      if (bytes_owed == '0) begin
        res.is_start = 1'b1;
        cur_op       = b;
        instr_off    = '0;
        if (scan_addr == '0 && b != OpEnter) begin
          sticky_err = VerdictFirstNotEnter;
        end else if (b == OpEnter) begin
          bytes_owed = EnterTail;
        end else if (b == OpSwitch) begin
          bytes_owed = SwitchTail;
        end else if (op_length(b) == 0) begin
          sticky_err = VerdictBadOpcode;
        end else begin
          bytes_owed = LeftBits'(op_length(b) - 1);
        end
      end else begin
        if (instr_off != OffsetMax) instr_off = instr_off + 1'b1;
        bytes_owed = bytes_owed - 1'b1;
        if (cur_op == OpEnter && instr_off == EnterLenOffset) begin
          bytes_owed = LeftBits'(b);
        end else if (cur_op == OpSwitch && instr_off == SwitchLenOffset) begin
          bytes_owed = LeftBits'(SwitchCaseBytes * b);
        end
      end
    end
    if (sticky_err != VerdictPending) res.verdict = sticky_err;
    else if (fin) res.verdict = (bytes_owed != '0) ? VerdictTruncated : VerdictValid;
    else res.verdict = VerdictPending;
    scan_results_due = {scan_results_due, res};
    if (fin) clear_scan();
    else scan_addr = scan_addr + 1'b1;
  endfunction

  // result checking
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (scan_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: addr %0d start %0b final %0b verdict %0d",
                   result_ch.byte_address, result_ch.is_start, result_ch.is_final,
                   result_ch.verdict);
      end else begin
        want = scan_results_due.pop_front();
        if (result_ch.byte_address !== want.byte_address ||
            result_ch.is_start !== want.is_start ||
            result_ch.is_final !== want.is_final || result_ch.verdict !== want.verdict) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr %0d start %0b final %0b verdict %0d,",
                     want.byte_address, want.is_start, want.is_final, want.verdict,
                     " got addr %0d start %0b final %0b verdict %0d",
                     result_ch.byte_address, result_ch.is_start, result_ch.is_final,
                     result_ch.verdict);
        end
      end
    end
  end

  // receiver side: random stalls between transfers when enabled
  initial begin : drive_ready
    int unsigned gap;
    result_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = recv_idle_on ? $urandom_range(0, MaxIdle) : 0;
      if (gap != 0) begin
        result_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = send_idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap != 0) begin
      byte_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid     = 1'b1;
    byte_ch.code_byte = b;
    byte_ch.last      = fin;
    do @(posedge clk); while (!byte_ch.ready);
    scan_byte(b, fin);
    @(negedge clk);
  endtask

  task automatic send_stream(input byte_q_t s);
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic wait_drained();
    byte_ch.valid = 1'b0;
    while (scan_results_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic void push_instr(ref byte_q_t q, input logic [7:0] op);
    bit big;
    int unsigned n;
    big = ($urandom_range(0, 99) == 0);
    q = {q, op};
    if (op == OpEnter) begin
      n = big ? $urandom_range(0, 255) : $urandom_range(0, 3);
      repeat (3) q = {q, 8'($urandom)};
      q = {q, 8'(n)};
      repeat (n) q = {q, 8'($urandom)};
    end else if (op == OpSwitch) begin
      n = big ? $urandom_range(0, 255) : $urandom_range(0, 2);
      q = {q, 8'(n)};
      repeat (SwitchCaseBytes * n) q = {q, 8'($urandom)};
    end else begin
      repeat (op_length(op) - 1) q = {q, 8'($urandom)};
    end
  endfunction

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(0, 9))
      0: return OpEnter;
      1: return OpSwitch;
      default: return 8'($urandom_range(0, OpLastValid));
    endcase
  endfunction

  function automatic void build_program(ref byte_q_t s);
    push_instr(s, OpEnter);
    repeat ($urandom_range(0, 7)) push_instr(s, pick_opcode());
  endfunction

  function automatic byte_q_t build_stream();
    byte_q_t s;
    logic [7:0] b;
    int unsigned kind;
    kind = $urandom_range(0, 19);
    if (kind <= 11) begin
      build_program(s);
    end else if (kind <= 14) begin
      build_program(s);
      s = s[0:$urandom_range(0, s.size() - 2)];
    end else if (kind <= 16) begin
      build_program(s);
      s = {s, 8'($urandom_range(OpLastValid + 1, 255))};
      repeat ($urandom_range(0, 3)) s = {s, 8'($urandom)};
    end else if (kind == 17) begin
      do b = 8'($urandom); while (b == OpEnter);
      s = {s, b};
      repeat ($urandom_range(0, 3)) s = {s, 8'($urandom)};
    end else begin
      repeat ($urandom_range(1, 12)) s = {s, 8'($urandom)};
    end
    return s;
  endfunction

  task automatic run_streams(input int unsigned byte_goal);
    int unsigned sent;
    byte_q_t s;
    sent = 0;
    while (sent < byte_goal) begin
      s = build_stream();
      send_stream(s);
      sent += s.size();
    end
  endtask

  task automatic test_directed_streams();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    send_stream('{OpEnter, 8'h00, 8'h00, 8'h00, 8'h00});
    send_stream('{8'h00});
    send_stream('{OpEnter, 8'h00, 8'h00, 8'h00, 8'h00, OpAllOnes, 8'h00});
    send_stream('{OpEnter, 8'h00, 8'h00, 8'h00, 8'h01, 8'hAA, OpSwitch, 8'h00, OpTwoByte});
    send_stream('{OpEnter});
    wait_drained();
  endtask

  task automatic test_random_traffic();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    run_streams(650);
    wait_drained();
    run_streams(650);
    wait_drained();
  endtask

  task automatic test_full_rate();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    run_streams(300);
    wait_drained();
  endtask

  task automatic test_receiver_stall();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b1;
    run_streams(300);
    wait_drained();
  endtask

  initial begin
    mismatches        = 0;
    send_idle_on      = 1'b1;
    recv_idle_on      = 1'b1;
    rst_n             = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.code_byte = 8'h00;
    byte_ch.last      = 1'b0;
    clear_scan();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_streams();
    test_random_traffic();
    test_full_rate();
    test_receiver_stall();
    wait_drained();
    if (mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
